// ----- hdl/tos_pkg.sv -----
// ----------------------------------------------------------------------------
// tos_pkg
// Shared types and constants for the TCP option scanner.
// ----------------------------------------------------------------------------
package tos_pkg;

  localparam logic [7:0] KIND_END     = 8'd0;
  localparam logic [7:0] KIND_PAD     = 8'd1;
  localparam logic [7:0] MIN_OPT_LEN  = 8'd2;
  localparam logic [7:0] TARGET_RESET = 8'd8;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    PH_KIND = 2'd0,
    PH_LEN  = 2'd1,
    PH_SKIP = 2'd2,
    PH_STOP = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    ST_END      = 2'd0,
    ST_RAN_OUT  = 2'd1,
    ST_SHORT    = 2'd2,
    ST_OVERRUN  = 2'd3
  } status_e;

  // classified byte as it travels from front to back
  typedef struct packed {
    logic [7:0] data;
    logic       is_end;
    logic       is_pad;
    logic       kind_hit;
    logic       pad_hit;
    logic       last;
    logic       empty;
  } item_t;

endpackage

// ----- hdl/tos_front.sv -----
// ----------------------------------------------------------------------------
// tos_front
// Holds the target kind register and classifies incoming option bytes.
// ----------------------------------------------------------------------------
module tos_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [7:0]    cfg_data_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    option_byte_i,
  input  logic          last_byte_i,
  input  logic          empty_area_i,
  output logic          push_o,
  output tos_pkg::item_t push_item_o,
  input  logic          q_full_i
);
  import tos_pkg::*;

  logic [7:0] target_kind_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_kind_q <= TARGET_RESET;
    end else if (cfg_valid_i) begin
      target_kind_q <= cfg_data_i;
    end
  end

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    push_item_o.data     = option_byte_i;
    push_item_o.is_end   = (option_byte_i == KIND_END);
    push_item_o.is_pad   = (option_byte_i == KIND_PAD);
    push_item_o.kind_hit = (option_byte_i == target_kind_q);
    push_item_o.pad_hit  = (target_kind_q == KIND_PAD);
    push_item_o.last     = last_byte_i;
    push_item_o.empty    = empty_area_i;
  end

endmodule

// ----- hdl/tos_queue.sv -----
// ----------------------------------------------------------------------------
// tos_queue
// Short FIFO of classified bytes between front and back.
// ----------------------------------------------------------------------------
module tos_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tos_pkg::item_t push_item_i,
  output logic           full_o,
  output logic           valid_o,
  output tos_pkg::item_t head_o,
  input  logic           pop_i
);
  import tos_pkg::*;

  item_t             entry_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == QCNT_W'(QDEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QDEPTH)) else $error("queue count out of range");

endmodule

// ----- hdl/tos_back.sv -----
// ----------------------------------------------------------------------------
// tos_back
// Option walker: updates scan state per byte and registers the area result.
// ----------------------------------------------------------------------------
module tos_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  tos_pkg::item_t head_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic           target_found_o,
  output logic [1:0]     scan_status_o
);
  import tos_pkg::*;

  phase_e     phase_q, phase_d;
  logic [7:0] skip_q, skip_d;
  logic       opt_tgt_q, opt_tgt_d;
  logic       seen_q, seen_d;
  status_e    held_q, held_d;

  logic       out_valid_q;
  logic       found_q;
  status_e    status_q;

  logic       ends_area;
  logic       res_found;
  status_e    res_status;

  // next state
  always_comb begin
    phase_d   = phase_q;
    skip_d    = skip_q;
    opt_tgt_d = opt_tgt_q;
    seen_d    = seen_q;
    held_d    = held_q;
    if (!head_i.empty) begin
      unique case (phase_q)
        PH_KIND: begin
          if (head_i.is_end) begin
            phase_d = PH_STOP;
            held_d  = ST_END;
          end else if (head_i.is_pad) begin
            if (head_i.pad_hit) seen_d = 1'b1;
          end else begin
            opt_tgt_d = head_i.kind_hit;
            phase_d   = PH_LEN;
          end
        end
        PH_LEN: begin
          if (head_i.data < MIN_OPT_LEN) begin
            phase_d = PH_STOP;
            held_d  = ST_SHORT;
          end else if (head_i.data == MIN_OPT_LEN) begin
            seen_d    = seen_q | opt_tgt_q;
            opt_tgt_d = 1'b0;
            phase_d   = PH_KIND;
          end else begin
            skip_d  = head_i.data - MIN_OPT_LEN;
            phase_d = PH_SKIP;
          end
        end
        PH_SKIP: begin
          if (skip_q <= 8'd1) begin
            skip_d    = '0;
            seen_d    = seen_q | opt_tgt_q;
            opt_tgt_d = 1'b0;
            phase_d   = PH_KIND;
          end else begin
            skip_d = skip_q - 8'd1;
          end
        end
        PH_STOP: begin
        end
        default: begin
        end
      endcase
    end
  end

  // outputs
  always_comb begin
    ends_area = head_i.last || head_i.empty;
    res_found = seen_d;
    unique case (phase_d)
      PH_KIND:          res_status = ST_RAN_OUT;
      PH_LEN, PH_SKIP:  res_status = ST_OVERRUN;
      PH_STOP:          res_status = held_d;
      default:          res_status = held_d;
    endcase
    pop_o = q_valid_i && (!ends_area || !out_valid_q || out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_KIND;
      skip_q    <= '0;
      opt_tgt_q <= 1'b0;
      seen_q    <= 1'b0;
      held_q    <= ST_END;
    end else if (pop_o) begin
      if (ends_area) begin
        phase_q   <= PH_KIND;
        skip_q    <= '0;
        opt_tgt_q <= 1'b0;
        seen_q    <= 1'b0;
        held_q    <= ST_END;
      end else begin
        phase_q   <= phase_d;
        skip_q    <= skip_d;
        opt_tgt_q <= opt_tgt_d;
        seen_q    <= seen_d;
        held_q    <= held_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o && ends_area) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && ends_area) begin
      found_q  <= res_found;
      status_q <= res_status;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign target_found_o = found_q;
  assign scan_status_o  = status_q;

  a_skip_only_in_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_SKIP) |-> (skip_q == '0)) else $error("stray skip count");
  a_no_target_at_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_KIND) |-> !opt_tgt_q) else $error("target flag left set");
  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && ends_area) |=> out_valid_q) else $error("result not loaded");
  a_state_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && ends_area) |=> (phase_q == PH_KIND && !seen_q))
    else $error("scan state not cleared after area");

endmodule

// ----- hdl/tcp_option_scanner_top.sv -----
// ----------------------------------------------------------------------------
// tcp_option_scanner_top
// Walks TCP option areas byte by byte and reports target presence and
// scan termination per area.
//
//   channel  direction  payload                                  transfer
//   cfg      in         cfg_data_i (target kind)                 valid/ready
//   in       in         option_byte_i, last_byte_i, empty_area_i valid/ready
//   out      out        target_found_o, scan_status_o            valid/ready
//
// One byte per cycle sustained while out_ready_i takes results; out_valid_o rises
// after the byte that ends its area passes the queue entry, then the output register.
// A two-entry queue separates the classifier from the walker; while a result
// waits, bytes keep flowing until an area-ending byte reaches the walker and
// the queue fills, then in_ready_o drops.
// Reset restores target kind 8 and an empty scan; cfg_ready_o is always high.
// ----------------------------------------------------------------------------
module tcp_option_scanner_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] option_byte_i,
  input  logic       last_byte_i,
  input  logic       empty_area_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       target_found_o,
  output logic [1:0] scan_status_o
);
  import tos_pkg::*;

  logic  push;
  item_t push_item;
  logic  q_full;
  logic  q_valid;
  item_t q_head;
  logic  pop;

  tos_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .option_byte_i (option_byte_i),
    .last_byte_i   (last_byte_i),
    .empty_area_i  (empty_area_i),
    .push_o        (push),
    .push_item_o   (push_item),
    .q_full_i      (q_full)
  );

  tos_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .head_o      (q_head),
    .pop_i       (pop)
  );

  tos_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .head_i         (q_head),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .target_found_o (target_found_o),
    .scan_status_o  (scan_status_o)
  );

endmodule
